// ----- rtl/core/sensorless_six_step_commutator_macros.svh -----
// assertion macros for the six-step commutator
// used by the top level only, needs a clk and rst in scope
`ifndef SENSORLESS_SIX_STEP_COMMUTATOR_MACROS_SVH
`define SENSORLESS_SIX_STEP_COMMUTATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ssc_pkg.sv -----
// shared types, constants and helpers for the six-step commutator
// no dependencies; used by every module of the block
package ssc_pkg;

  // commutation and sampling constants
  localparam int NUM_STEPS       = 6;
  localparam int SAMPLE_INTERVAL = 50;

  localparam int TimerW   = 24;
  localparam int SzcW     = 24;
  localparam int SstW     = 21;
  localparam int SampleW  = 6;
  localparam int StepW    = 3;
  localparam int DutyW    = 7;
  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 3;

  localparam logic [DutyW-1:0] DutyMax = 7'd100;

  // run modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ALIGN  = 3'd1,
    MODE_RAMP   = 3'd2,
    MODE_CLOSED = 3'd3,
    MODE_DELAY  = 3'd4,
    MODE_FAULT  = 3'd5
  } mode_t;

  // fault codes
  localparam logic [2:0] FAULT_NONE       = 3'd0;
  localparam logic [2:0] FAULT_RAMP_DRV   = 3'd1;
  localparam logic [2:0] FAULT_ADC        = 3'd2;
  localparam logic [2:0] FAULT_CLOSED_DRV = 3'd3;
  localparam logic [2:0] FAULT_STALL      = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ALIGN_DUTY   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ALIGN_TIME   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RAMP_DUTY    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RAMP_START   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RAMP_END     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RAMP_DEC     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CLOSED_DUTY  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_STALL_TIME   = 3'd7;

  // configuration registers
  typedef struct packed {
    logic [6:0]  align_duty;
    logic [19:0] align_time_us;
    logic [6:0]  ramp_duty;
    logic [15:0] ramp_start_period_us;
    logic [15:0] ramp_end_period_us;
    logic [11:0] ramp_decrement_us;
    logic [6:0]  closed_duty;
    logic [19:0] stall_timeout_us;
  } cfg_t;

  // one tick word
  typedef struct packed {
    logic start_req;
    logic bemf_cross;
    logic adc_ok;
    logic driver_ok;
  } tick_t;

  // one result word
  typedef struct packed {
    logic             drive_enable;
    logic [StepW-1:0] phase_step;
    logic [DutyW-1:0] duty_percent;
    mode_t            mode;
    logic [2:0]       fault_code;
    logic             commutated;
    logic             edge_reset;
    logic             sample_taken;
  } result_t;

  // saturate a duty register at full scale
  function automatic logic [DutyW-1:0] clamp_duty(input logic [DutyW-1:0] d);
    clamp_duty = (d > DutyMax) ? DutyMax : d;
  endfunction

  // next commutation step with wrap
  function automatic logic [StepW-1:0] step_after(input logic [StepW-1:0] s);
    logic [StepW:0] inc;
    inc = {1'b0, s} + 1'b1;
    step_after = (inc >= (StepW+1)'(NUM_STEPS)) ? '0 : inc[StepW-1:0];
  endfunction

endpackage

// ----- rtl/core/ssc_cfg.sv -----
// configuration register file for the six-step commutator
// depends on ssc_pkg for the register layout and index codes
module ssc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ssc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ssc_pkg::CfgDataW-1:0] cfg_wdata,
  output ssc_pkg::cfg_t                cfg
);

  // register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.align_duty           <= 7'd20;
      cfg.align_time_us        <= 20'd500000;
      cfg.ramp_duty            <= 7'd25;
      cfg.ramp_start_period_us <= 16'd8000;
      cfg.ramp_end_period_us   <= 16'd1500;
      cfg.ramp_decrement_us    <= 12'd40;
      cfg.closed_duty          <= 7'd35;
      cfg.stall_timeout_us     <= 20'd500000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ssc_pkg::REG_ALIGN_DUTY:  cfg.align_duty           <= cfg_wdata[6:0];
        ssc_pkg::REG_ALIGN_TIME:  cfg.align_time_us        <= cfg_wdata;
        ssc_pkg::REG_RAMP_DUTY:   cfg.ramp_duty            <= cfg_wdata[6:0];
        ssc_pkg::REG_RAMP_START:  cfg.ramp_start_period_us <= cfg_wdata[15:0];
        ssc_pkg::REG_RAMP_END:    cfg.ramp_end_period_us   <= cfg_wdata[15:0];
        ssc_pkg::REG_RAMP_DEC:    cfg.ramp_decrement_us    <= cfg_wdata[11:0];
        ssc_pkg::REG_CLOSED_DUTY: cfg.closed_duty          <= cfg_wdata[6:0];
        ssc_pkg::REG_STALL_TIME:  cfg.stall_timeout_us     <= cfg_wdata;
      endcase
    end
  end

endmodule

// ----- rtl/core/ssc_engine.sv -----
// run-mode sequencer: align, open-loop ramp, closed-loop commutation, faults
// depends on ssc_pkg; advances one tick whenever fire is high
module ssc_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ssc_pkg::tick_t     tick,
  input  ssc_pkg::cfg_t      cfg,
  output ssc_pkg::result_t   result
);

  ssc_pkg::mode_t                   mode, mode_next;
  logic [ssc_pkg::StepW-1:0]        step_index, step_index_next;
  logic [ssc_pkg::TimerW-1:0]       wait_timer, wait_timer_next;
  logic [15:0]                      ramp_period, ramp_period_next;
  logic [ssc_pkg::SzcW-1:0]         since_zc, since_zc_next;
  logic [ssc_pkg::SstW-1:0]         since_step, since_step_next;
  logic [ssc_pkg::SampleW-1:0]      sample_count, sample_count_next;
  logic [2:0]                       fault_latch, fault_latch_next;

  logic                             p_comm, p_edge, p_sample;
  logic [ssc_pkg::TimerW-1:0]       wt_dec;
  logic [ssc_pkg::SzcW-1:0]         szc_inc;
  logic [ssc_pkg::SstW-1:0]         sst_inc;
  logic [ssc_pkg::SampleW-1:0]      sc_inc;
  logic [ssc_pkg::TimerW-1:0]       half_int;
  logic [15:0]                      rp_cur;
  logic                             ramp_go, comm_go;
  logic [ssc_pkg::DutyW-1:0]        duty;

  // counter helpers shared by the mode arms
  always_comb begin
    wt_dec   = (wait_timer != '0) ? wait_timer - 1'b1 : wait_timer;
    szc_inc  = (since_zc != '1) ? since_zc + 1'b1 : since_zc;
    sst_inc  = (since_step != '1) ? since_step + 1'b1 : since_step;
    sc_inc   = sample_count + 1'b1;
    half_int = szc_inc >> 1;
  end

  // next-state logic for one tick
  always_comb begin
    mode_next         = mode;
    step_index_next   = step_index;
    wait_timer_next   = wait_timer;
    ramp_period_next  = ramp_period;
    since_zc_next     = since_zc;
    since_step_next   = since_step;
    sample_count_next = sample_count;
    fault_latch_next  = fault_latch;
    p_comm            = 1'b0;
    p_edge            = 1'b0;
    p_sample          = 1'b0;
    ramp_go           = 1'b0;
    comm_go           = 1'b0;
    rp_cur            = ramp_period;

    unique case (mode)
      ssc_pkg::MODE_IDLE, ssc_pkg::MODE_FAULT: begin
        if (tick.start_req) begin
          mode_next        = ssc_pkg::MODE_ALIGN;
          fault_latch_next = ssc_pkg::FAULT_NONE;
          step_index_next  = '0;
          wait_timer_next  = ssc_pkg::TimerW'(cfg.align_time_us);
          p_comm           = 1'b1;
        end
      end
      ssc_pkg::MODE_ALIGN: begin
        wait_timer_next = wt_dec;
        if (wt_dec == '0) begin
          rp_cur  = cfg.ramp_start_period_us;
          ramp_go = 1'b1;
        end
      end
      ssc_pkg::MODE_RAMP: begin
        wait_timer_next = wt_dec;
        if (wt_dec == '0) begin
          ramp_go = 1'b1;
        end
      end
      ssc_pkg::MODE_CLOSED: begin
        since_zc_next     = szc_inc;
        since_step_next   = sst_inc;
        sample_count_next = sc_inc;
        if (sc_inc >= ssc_pkg::SampleW'(ssc_pkg::SAMPLE_INTERVAL)) begin
          sample_count_next = '0;
          p_sample          = 1'b1;
          if (!tick.adc_ok) begin
            mode_next        = ssc_pkg::MODE_FAULT;
            fault_latch_next = ssc_pkg::FAULT_ADC;
            wait_timer_next  = '0;
          end else if (tick.bemf_cross) begin
            wait_timer_next = half_int;
            since_zc_next   = '0;
            if (half_int == '0) begin
              comm_go = 1'b1;
            end else begin
              mode_next = ssc_pkg::MODE_DELAY;
            end
          end else if (sst_inc > ssc_pkg::SstW'(cfg.stall_timeout_us)) begin
            mode_next        = ssc_pkg::MODE_FAULT;
            fault_latch_next = ssc_pkg::FAULT_STALL;
            wait_timer_next  = '0;
          end
        end
      end
      ssc_pkg::MODE_DELAY: begin
        since_zc_next   = szc_inc;
        since_step_next = sst_inc;
        wait_timer_next = wt_dec;
        if (wt_dec == '0) begin
          comm_go = 1'b1;
        end
      end
      default: begin
        mode_next        = ssc_pkg::MODE_IDLE;
        fault_latch_next = ssc_pkg::FAULT_NONE;
        wait_timer_next  = '0;
      end
    endcase

    // open-loop step, or hand-over to closed loop
    if (ramp_go) begin
      ramp_period_next = rp_cur;
      if (rp_cur > cfg.ramp_end_period_us) begin
        step_index_next = ssc_pkg::step_after(step_index);
        if (!tick.driver_ok) begin
          mode_next        = ssc_pkg::MODE_FAULT;
          fault_latch_next = ssc_pkg::FAULT_RAMP_DRV;
          wait_timer_next  = '0;
        end else begin
          p_comm           = 1'b1;
          wait_timer_next  = ssc_pkg::TimerW'(rp_cur);
          ramp_period_next = (rp_cur > 16'(cfg.ramp_decrement_us)) ?
                             rp_cur - 16'(cfg.ramp_decrement_us) : '0;
          mode_next        = ssc_pkg::MODE_RAMP;
        end
      end else begin
        mode_next         = ssc_pkg::MODE_CLOSED;
        p_edge            = 1'b1;
        since_zc_next     = '0;
        since_step_next   = '0;
        sample_count_next = '0;
        wait_timer_next   = '0;
      end
    end

    // closed-loop commutation
    if (comm_go) begin
      step_index_next = ssc_pkg::step_after(step_index);
      if (!tick.driver_ok) begin
        mode_next        = ssc_pkg::MODE_FAULT;
        fault_latch_next = ssc_pkg::FAULT_CLOSED_DRV;
        wait_timer_next  = '0;
      end else begin
        p_comm            = 1'b1;
        p_edge            = 1'b1;
        since_step_next   = '0;
        sample_count_next = '0;
        mode_next         = ssc_pkg::MODE_CLOSED;
      end
    end
  end

  // duty for the mode after this tick
  always_comb begin
    unique case (mode_next)
      ssc_pkg::MODE_ALIGN:  duty = ssc_pkg::clamp_duty(cfg.align_duty);
      ssc_pkg::MODE_RAMP:   duty = ssc_pkg::clamp_duty(cfg.ramp_duty);
      ssc_pkg::MODE_CLOSED,
      ssc_pkg::MODE_DELAY:  duty = ssc_pkg::clamp_duty(cfg.closed_duty);
      default:              duty = '0;
    endcase
  end

  // result word built from the post-tick state
  always_comb begin
    result.drive_enable = (mode_next != ssc_pkg::MODE_IDLE) &&
                          (mode_next != ssc_pkg::MODE_FAULT);
    result.phase_step   = step_index_next;
    result.duty_percent = duty;
    result.mode         = mode_next;
    result.fault_code   = fault_latch_next;
    result.commutated   = p_comm;
    result.edge_reset   = p_edge;
    result.sample_taken = p_sample;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ssc_pkg::MODE_IDLE;
      step_index   <= '0;
      wait_timer   <= '0;
      ramp_period  <= '0;
      since_zc     <= '0;
      since_step   <= '0;
      sample_count <= '0;
      fault_latch  <= ssc_pkg::FAULT_NONE;
    end else if (fire) begin
      mode         <= mode_next;
      step_index   <= step_index_next;
      wait_timer   <= wait_timer_next;
      ramp_period  <= ramp_period_next;
      since_zc     <= since_zc_next;
      since_step   <= since_step_next;
      sample_count <= sample_count_next;
      fault_latch  <= fault_latch_next;
    end
  end

endmodule

// ----- rtl/core/sensorless_six_step_commutator.sv -----
// top level of the sensorless six-step commutator: tick register, sequencer, result register
// depends on ssc_pkg, ssc_cfg, ssc_engine and sensorless_six_step_commutator_macros.svh
//
//   port group   direction  handshake              word
//   tick in      in         in_valid / in_ready    start_req bemf_cross adc_ok driver_ok
//   result out   out        out_valid / out_ready  drive_enable .. sample_taken
//   config       in         cfg_wr_en              cfg_index cfg_wdata
//
// one tick word per clock sustained while the output is not stalled; a word is held
// in the tick register until the sequencer takes it, and the result register is loaded
// on the same edge that updates the sequencer state.
// rst is synchronous and returns the block to idle with the default register values.
// a stalled output backs up into the tick register; in_ready drops only when both are full.
`include "sensorless_six_step_commutator_macros.svh"

module sensorless_six_step_commutator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         start_req,
  input  logic                         bemf_cross,
  input  logic                         adc_ok,
  input  logic                         driver_ok,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         drive_enable,
  output logic [2:0]                   phase_step,
  output logic [6:0]                   duty_percent,
  output logic [2:0]                   mode,
  output logic [2:0]                   fault_code,
  output logic                         commutated,
  output logic                         edge_reset,
  output logic                         sample_taken,
  input  logic                         cfg_wr_en,
  input  logic [ssc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ssc_pkg::CfgDataW-1:0] cfg_wdata
);

  ssc_pkg::cfg_t    cfg;
  ssc_pkg::tick_t   s1_tick;
  ssc_pkg::result_t eng_result;
  ssc_pkg::result_t out_word;
  logic             s1_valid;
  logic             s1_adv;
  logic             fire;
  logic             in_take;

  // handshake control
  assign s1_adv   = !out_valid || out_ready;
  assign fire     = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;
  assign in_take  = in_valid && in_ready;

  // configuration registers
  ssc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tick.start_req  <= start_req;
      s1_tick.bemf_cross <= bemf_cross;
      s1_tick.adc_ok     <= adc_ok;
      s1_tick.driver_ok  <= driver_ok;
    end
  end

  // sequencer
  ssc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .tick   (s1_tick),
    .cfg    (cfg),
    .result (eng_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= eng_result;
    end
  end

  // result fields
  assign drive_enable = out_word.drive_enable;
  assign phase_step   = out_word.phase_step;
  assign duty_percent = out_word.duty_percent;
  assign mode         = out_word.mode;
  assign fault_code   = out_word.fault_code;
  assign commutated   = out_word.commutated;
  assign edge_reset   = out_word.edge_reset;
  assign sample_taken = out_word.sample_taken;

  // checks
  `SSC_ASSERT_NOW(a_drive_matches_mode, out_valid,
    drive_enable == (out_word.mode == ssc_pkg::MODE_ALIGN ||
                     out_word.mode == ssc_pkg::MODE_RAMP ||
                     out_word.mode == ssc_pkg::MODE_CLOSED ||
                     out_word.mode == ssc_pkg::MODE_DELAY),
    "drive enable disagrees with run mode")
  `SSC_ASSERT_NOW(a_fault_code_only_in_fault, out_valid && fault_code != ssc_pkg::FAULT_NONE,
    out_word.mode == ssc_pkg::MODE_FAULT, "fault code latched outside fault mode")
  `SSC_ASSERT_NOW(a_no_duty_when_off, out_valid && !drive_enable,
    duty_percent == '0, "duty applied with drive disabled")
  `SSC_ASSERT_NEXT(a_tick_held_on_stall, s1_valid && !s1_adv,
    s1_valid && $stable(s1_tick), "pending tick lost while result stalled")

endmodule

// ----- tb/sensorless_six_step_commutator_tb.sv -----
// testbench for the sensorless six-step commutator: directed and random tick words
// checked word by word against a predictor of the mode sequencer
// depends on ssc_pkg and the rtl of sensorless_six_step_commutator
`timescale 1ns / 100ps

module sensorless_six_step_commutator_tb;
  import ssc_pkg::*;

  localparam int RUN_LIMIT  = 200000;
  localparam int SETTLE     = 4;
  localparam int END_WAIT   = 8;
  localparam int MAX_REPORT = 10;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                start_req    = 1'b0;
  logic                bemf_cross   = 1'b0;
  logic                adc_ok       = 1'b0;
  logic                driver_ok    = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                drive_enable;
  logic [2:0]          phase_step;
  logic [6:0]          duty_percent;
  logic [2:0]          mode;
  logic [2:0]          fault_code;
  logic                commutated;
  logic                edge_reset;
  logic                sample_taken;
  logic                cfg_wr_en    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  logic [CfgDataW-1:0] cfg_wdata    = '0;

  sensorless_six_step_commutator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_req    (start_req),
    .bemf_cross   (bemf_cross),
    .adc_ok       (adc_ok),
    .driver_ok    (driver_ok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_enable (drive_enable),
    .phase_step   (phase_step),
    .duty_percent (duty_percent),
    .mode         (mode),
    .fault_code   (fault_code),
    .commutated   (commutated),
    .edge_reset   (edge_reset),
    .sample_taken (sample_taken),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // tick words waiting to be sent, drive words predicted for the output
  tick_t   tick_backlog[$];
  result_t predicted_drive[$];

  int          mismatches  = 0;
  int          cycle_count = 0;
  logic        word_taken  = 1'b0;
  int          gap_left    = 0;
  int          burst_left  = 0;
  int          seg_left    = 0;
  logic        noisy_seg   = 1'b0;
  logic [15:0] ready_pattern = '1;
  logic [6:0]  ready_phase   = '0;

  // shadow of the register file, reset values
  cfg_t shadow_cfg = '{align_duty: 7'd20, align_time_us: 20'd500000, ramp_duty: 7'd25,
                       ramp_start_period_us: 16'd8000, ramp_end_period_us: 16'd1500,
                       ramp_decrement_us: 12'd40, closed_duty: 7'd35,
                       stall_timeout_us: 20'd500000};

  // predicted sequencer state
  mode_t             sq_mode     = MODE_IDLE;
  logic [StepW-1:0]  sq_step     = '0;
  logic [TimerW-1:0] sq_hold     = '0;
  logic [15:0]       sq_period   = '0;
  logic [SzcW-1:0]   sq_zc_age   = '0;
  logic [SstW-1:0]   sq_step_age = '0;
  logic [SampleW-1:0] sq_samples = '0;
  logic [2:0]        sq_fault    = FAULT_NONE;
  logic              pulse_comm, pulse_edge, pulse_sample;

  // clock
  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  function automatic logic [StepW-1:0] following_step(input logic [StepW-1:0] s);
    return (int'(s) + 1 >= NUM_STEPS) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [DutyW-1:0] capped(input logic [DutyW-1:0] d);
    return (d > 7'd100) ? 7'd100 : d;
  endfunction

  function automatic void latch_fault(input logic [2:0] code);
    sq_mode  = MODE_FAULT;
    sq_fault = code;
    sq_hold  = '0;
  endfunction

  // open-loop step, or hand over to closed loop once the period is short enough
  function automatic void ramp_step(input logic drv);
    if (sq_period > shadow_cfg.ramp_end_period_us) begin
      sq_step = following_step(sq_step);
      if (!drv) begin
        latch_fault(FAULT_RAMP_DRV);
      end else begin
        pulse_comm = 1'b1;
        sq_hold    = TimerW'(sq_period);
        sq_period  = (sq_period > shadow_cfg.ramp_decrement_us) ?
                     sq_period - shadow_cfg.ramp_decrement_us : '0;
        sq_mode    = MODE_RAMP;
      end
    end else begin
      sq_mode     = MODE_CLOSED;
      pulse_edge  = 1'b1;
      sq_zc_age   = '0;
      sq_step_age = '0;
      sq_samples  = '0;
      sq_hold     = '0;
    end
  endfunction

  // closed-loop commutation
  function automatic void closed_step(input logic drv);
    sq_step = following_step(sq_step);
    if (!drv) begin
      latch_fault(FAULT_CLOSED_DRV);
    end else begin
      pulse_comm  = 1'b1;
      pulse_edge  = 1'b1;
      sq_step_age = '0;
      sq_samples  = '0;
      sq_mode     = MODE_CLOSED;
    end
  endfunction

  function automatic void age_counters();
    if (sq_zc_age != '1) sq_zc_age = sq_zc_age + 1'b1;
    if (sq_step_age != '1) sq_step_age = sq_step_age + 1'b1;
  endfunction

  // advance the predicted sequencer by one tick and return the drive word
  function automatic result_t commutate_tick(input tick_t t);
    result_t r;
    pulse_comm   = 1'b0;
    pulse_edge   = 1'b0;
    pulse_sample = 1'b0;
    case (sq_mode)
      MODE_IDLE, MODE_FAULT: begin
        if (t.start_req) begin
          sq_mode    = MODE_ALIGN;
          sq_fault   = FAULT_NONE;
          sq_step    = '0;
          sq_hold    = TimerW'(shadow_cfg.align_time_us);
          pulse_comm = 1'b1;
        end
      end
      MODE_ALIGN: begin
        if (sq_hold != 0) sq_hold = sq_hold - 1'b1;
        if (sq_hold == 0) begin
          sq_period = shadow_cfg.ramp_start_period_us;
          ramp_step(t.driver_ok);
        end
      end
      MODE_RAMP: begin
        if (sq_hold != 0) sq_hold = sq_hold - 1'b1;
        if (sq_hold == 0) ramp_step(t.driver_ok);
      end
      MODE_CLOSED: begin
        age_counters();
        sq_samples = sq_samples + 1'b1;
        if (sq_samples >= SAMPLE_INTERVAL) begin
          sq_samples   = '0;
          pulse_sample = 1'b1;
          if (!t.adc_ok) begin
            latch_fault(FAULT_ADC);
          end else if (t.bemf_cross) begin
            // wait half the zero-cross interval
            sq_hold   = sq_zc_age >> 1;
            sq_zc_age = '0;
            if (sq_hold == 0) closed_step(t.driver_ok);
            else sq_mode = MODE_DELAY;
          end else if (sq_step_age > shadow_cfg.stall_timeout_us) begin
            latch_fault(FAULT_STALL);
          end
        end
      end
      MODE_DELAY: begin
        age_counters();
        if (sq_hold != 0) sq_hold = sq_hold - 1'b1;
        if (sq_hold == 0) closed_step(t.driver_ok);
      end
      default: begin
        latch_fault(FAULT_NONE);
        sq_mode = MODE_IDLE;
      end
    endcase

    r.drive_enable = (sq_mode != MODE_IDLE) && (sq_mode != MODE_FAULT);
    r.phase_step   = sq_step;
    case (sq_mode)
      MODE_ALIGN:             r.duty_percent = capped(shadow_cfg.align_duty);
      MODE_RAMP:              r.duty_percent = capped(shadow_cfg.ramp_duty);
      MODE_CLOSED, MODE_DELAY: r.duty_percent = capped(shadow_cfg.closed_duty);
      default:                r.duty_percent = '0;
    endcase
    r.mode         = sq_mode;
    r.fault_code   = sq_fault;
    r.commutated   = pulse_comm;
    r.edge_reset   = pulse_edge;
    r.sample_taken = pulse_sample;
    return r;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("en=%0b step=%0d duty=%0d mode=%0d fault=%0d comm=%0b edge=%0b smp=%0b",
                     r.drive_enable, r.phase_step, r.duty_percent, r.mode, r.fault_code,
                     r.commutated, r.edge_reset, r.sample_taken);
  endfunction

  function automatic void flag_failure(input string what, input result_t want,
                                       input result_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORT)
      $display("[%0t] %s\n  expected %s\n  actual   %s", $realtime, what,
               describe(want), describe(seen));
  endfunction

  // random tick words: mostly plausible flags, with stretches of noise
  function automatic void queue_random(input int count);
    tick_t t;
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        seg_left  = $urandom_range(20, 80);
        noisy_seg = ($urandom_range(0, 99) < 15);
      end
      seg_left--;
      if (noisy_seg) begin
        t = tick_t'($urandom_range(0, 15));
      end else begin
        t.start_req  = ($urandom_range(0, 99) < 4);
        t.bemf_cross = ($urandom_range(0, 99) < 35);
        t.adc_ok     = ($urandom_range(0, 99) < 98);
        t.driver_ok  = ($urandom_range(0, 99) < 95);
      end
      tick_backlog.push_back(t);
    end
  endfunction

  // one register write, mirrored into the shadow copy
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgDataW'(val);
    case (idx)
      REG_ALIGN_DUTY:  shadow_cfg.align_duty           = 7'(val);
      REG_ALIGN_TIME:  shadow_cfg.align_time_us        = 20'(val);
      REG_RAMP_DUTY:   shadow_cfg.ramp_duty            = 7'(val);
      REG_RAMP_START:  shadow_cfg.ramp_start_period_us = 16'(val);
      REG_RAMP_END:    shadow_cfg.ramp_end_period_us   = 16'(val);
      REG_RAMP_DEC:    shadow_cfg.ramp_decrement_us    = 12'(val);
      REG_CLOSED_DUTY: shadow_cfg.closed_duty          = 7'(val);
      REG_STALL_TIME:  shadow_cfg.stall_timeout_us     = 20'(val);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned a_duty, a_time, r_duty, r_start, r_end,
                                r_dec, c_duty, stall);
    write_reg(REG_ALIGN_DUTY, a_duty);
    write_reg(REG_ALIGN_TIME, a_time);
    write_reg(REG_RAMP_DUTY, r_duty);
    write_reg(REG_RAMP_START, r_start);
    write_reg(REG_RAMP_END, r_end);
    write_reg(REG_RAMP_DEC, r_dec);
    write_reg(REG_CLOSED_DUTY, c_duty);
    write_reg(REG_STALL_TIME, stall);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // short alignment and ramp so that closed loop is reached quickly
  task automatic typical_settings(input int unsigned stall);
    apply_settings($urandom_range(0, 127), $urandom_range(0, 10), $urandom_range(0, 127),
                   $urandom_range(10, 40), $urandom_range(0, 12), $urandom_range(1, 8),
                   $urandom_range(0, 127), stall);
  endtask

  // wait until every word is sent and every drive word has come back
  task automatic drain();
    while (tick_backlog.size() != 0 || in_valid || predicted_drive.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sender: bursts of words with random gaps
  always @(negedge clk) begin : sender
    tick_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (tick_backlog.size() != 0) begin
        t = tick_backlog.pop_front();
        in_valid   <= 1'b1;
        start_req  <= t.start_req;
        bemf_cross <= t.bemf_cross;
        adc_ok     <= t.adc_ok;
        driver_ok  <= t.driver_ok;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern redrawn each time the 7-bit phase counter wraps, sometimes never stalling
  always @(negedge clk) begin : receiver
    if (ready_phase == 0)
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h1);
    out_ready <= ready_pattern[ready_phase[3:0]];
    ready_phase = ready_phase + 1'b1;
  end

  // monitor: predict on accepted tick words, check accepted drive words
  always @(posedge clk) begin : monitor
    result_t seen, want;
    word_taken = in_valid && in_ready;
    if (!rst) begin
      if (word_taken)
        predicted_drive.push_back(commutate_tick({start_req, bemf_cross, adc_ok, driver_ok}));
      if (out_valid && out_ready) begin
        seen = {drive_enable, phase_step, duty_percent, mode, fault_code,
                commutated, edge_reset, sample_taken};
        if (predicted_drive.size() == 0) begin
          flag_failure("drive word with nothing predicted", '0, seen);
        end else begin
          want = predicted_drive.pop_front();
          if (seen !== want) flag_failure("drive word mismatch", want, seen);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // keep reset defaults except a short alignment and a ramp start below its end
    write_reg(REG_ALIGN_TIME, 3);
    write_reg(REG_RAMP_START, 30);
    @(negedge clk);
    cfg_wr_en <= 1'b0;

    // every flag pattern: idle words, start, start while aligning, driver ignored in align
    for (int v = 0; v < 16; v++) tick_backlog.push_back(tick_t'(v));
    drain();

    // all minimum: alignment ends at once, closed loop at once, stall on first sample
    apply_settings(0, 0, 0, 0, 0, 1, 0, 1);
    queue_random(300);
    drain();

    typical_settings($urandom_range(40, 250));
    queue_random(350);
    drain();

    // duties above full scale, ramp period dropping below the decrement
    apply_settings(127, 2, 101, 9, 0, 4095, 127, $urandom_range(40, 150));
    queue_random(250);
    drain();

    typical_settings($urandom_range(40, 250));
    queue_random(400);
    drain();

    // stall check effectively off
    typical_settings(1048575);
    queue_random(350);
    drain();

    // all maximum, last since a start here holds alignment for the rest of the run
    apply_settings(100, 1048575, 127, 65535, 65535, 4095, 100, 1048575);
    queue_random(200);
    drain();

    repeat (END_WAIT) @(posedge clk);
    mismatches += predicted_drive.size();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ssc_pkg.sv
rtl/core/ssc_cfg.sv
rtl/core/ssc_engine.sv
rtl/core/sensorless_six_step_commutator.sv
tb/sensorless_six_step_commutator_tb.sv
